@@ sv/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and the digit to segment table for the
// three-digit seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int DIGIT_COUNT  = 3;
  localparam int SEG_W        = 7;
  localparam int NUMBER_W     = 10;
  localparam int PERIOD_W     = 8;
  localparam int INDEX_W      = 2;
  localparam int NUMBER_MAX   = 999;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PERIOD_RESET = 4;

  localparam logic [SEG_W-1:0] SEG_ZERO  = 7'h3F;
  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef logic [SEG_W-1:0] seg_t;

  typedef struct packed {
    op_t                     op;
    seg_t [DIGIT_COUNT-1:0]  pat;
  } item_t;

  function automatic seg_t seg_of(input logic [3:0] digit);
    seg_t s;
    unique case (digit)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

@@ sv/ssd_front.sv @@
// ----------------------------------------------------------------------------
// ssd_front
// Accepts items, saturates the number and splits it into segment patterns
// with leading zero blanking, then hands the word to the queue.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [ssd_pkg::NUMBER_W-1:0]  in_number,
  output logic                          wr_valid,
  input  logic                          wr_ready,
  output ssd_pkg::item_t                wr_item
);

  logic [ssd_pkg::NUMBER_W-1:0] num;
  logic [ssd_pkg::NUMBER_W-1:0] rem_h;
  logic [6:0]                   rem;
  logic [6:0]                   rem_t;
  logic [3:0]                   hund;
  logic [3:0]                   tens;
  logic [3:0]                   units;

  assign in_ready = wr_ready;
  assign wr_valid = in_valid;

  always_comb begin
    num = (in_number > ssd_pkg::NUMBER_W'(ssd_pkg::NUMBER_MAX)) ?
          ssd_pkg::NUMBER_W'(ssd_pkg::NUMBER_MAX) : in_number;
    hund = 4'd0;
    for (int h = 1; h <= 9; h++) begin
      if (num >= ssd_pkg::NUMBER_W'(h * 100)) begin
        hund = 4'(h);
      end
    end
    rem_h = num - (ssd_pkg::NUMBER_W'(hund) * ssd_pkg::NUMBER_W'(100));
    rem   = rem_h[6:0];
    tens  = 4'd0;
    for (int t = 1; t <= 9; t++) begin
      if (rem >= 7'(t * 10)) begin
        tens = 4'(t);
      end
    end
    rem_t = rem - (7'(tens) * 7'd10);
    units = rem_t[3:0];
  end

  always_comb begin
    wr_item.op     = ssd_pkg::op_t'(in_op);
    wr_item.pat[0] = ssd_pkg::seg_of(units);
    wr_item.pat[1] = (num >= ssd_pkg::NUMBER_W'(10)) ?
                     ssd_pkg::seg_of(tens) : ssd_pkg::SEG_BLANK;
    wr_item.pat[2] = (num >= ssd_pkg::NUMBER_W'(100)) ?
                     ssd_pkg::seg_of(hund) : ssd_pkg::SEG_BLANK;
  end

endmodule

@@ sv/ssd_queue.sv @@
// ----------------------------------------------------------------------------
// ssd_queue
// Short word queue between the front and back so each side stalls on
// its own.
// ----------------------------------------------------------------------------
module ssd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  ssd_pkg::item_t  wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output ssd_pkg::item_t  rd_item
);

  ssd_pkg::item_t                 mem_r [ssd_pkg::QUEUE_DEPTH];
  logic [ssd_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ssd_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ssd_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           push;
  logic                           pop;

  assign wr_ready = (count_r != ssd_pkg::QCNT_W'(ssd_pkg::QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ssd_pkg::QPTR_W'(ssd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ssd_pkg::QPTR_W'(ssd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + ssd_pkg::QCNT_W'(push) - ssd_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ sv/ssd_back.sv @@
// ----------------------------------------------------------------------------
// ssd_back
// Executes queued words: counts ticks, runs the multiplex step, keeps the
// shown and pending buffers and the drive registers, and holds the result.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [ssd_pkg::PERIOD_W-1:0]       cfg_data,
  input  logic                               rd_valid,
  output logic                               rd_ready,
  input  ssd_pkg::item_t                     rd_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ssd_pkg::SEG_W-1:0]          out_segments,
  output logic [ssd_pkg::DIGIT_COUNT-1:0]    out_digit_enable,
  output logic                               out_scanned
);

  logic [ssd_pkg::PERIOD_W-1:0]          period_r;
  ssd_pkg::seg_t [ssd_pkg::DIGIT_COUNT-1:0] shown_r, shown_nxt;
  ssd_pkg::seg_t [ssd_pkg::DIGIT_COUNT-1:0] pending_r;
  ssd_pkg::seg_t [ssd_pkg::DIGIT_COUNT-1:0] src;
  logic                                  pend_r, pend_nxt;
  logic [ssd_pkg::INDEX_W-1:0]           idx_r, idx_nxt, idx_cur;
  logic [ssd_pkg::PERIOD_W-1:0]          tick_r, tick_nxt, tick_inc;
  logic [ssd_pkg::SEG_W-1:0]             seg_r, seg_nxt;
  logic [ssd_pkg::DIGIT_COUNT-1:0]       en_r, en_nxt;
  logic                                  valid_r, valid_nxt;
  logic                                  scanned_r, scanned_nxt;
  logic                                  go;
  logic                                  step;

  assign rd_ready         = !valid_r || out_ready;
  assign go               = rd_valid && rd_ready;
  assign out_valid        = valid_r;
  assign out_segments     = seg_r;
  assign out_digit_enable = en_r;
  assign out_scanned      = scanned_r;

  always_comb begin
    tick_inc  = tick_r + 1'b1;
    step      = go && (rd_item.op == ssd_pkg::OP_TICK) && (tick_inc >= period_r);
    src       = pend_r ? pending_r : shown_r;
    idx_cur   = (idx_r >= ssd_pkg::INDEX_W'(ssd_pkg::DIGIT_COUNT)) ? '0 : idx_r;
    tick_nxt  = tick_r;
    shown_nxt = shown_r;
    pend_nxt  = pend_r;
    idx_nxt   = idx_r;
    seg_nxt   = seg_r;
    en_nxt    = en_r;
    if (go) begin
      if (rd_item.op == ssd_pkg::OP_LOAD) begin
        pend_nxt = 1'b1;
      end else if (step) begin
        tick_nxt  = '0;
        shown_nxt = src;
        pend_nxt  = 1'b0;
        seg_nxt   = src[idx_cur];
        en_nxt    = ssd_pkg::DIGIT_COUNT'(1) << idx_cur;
        idx_nxt   = (idx_cur == ssd_pkg::INDEX_W'(ssd_pkg::DIGIT_COUNT - 1)) ?
                    '0 : idx_cur + 1'b1;
      end else begin
        tick_nxt = tick_inc;
      end
    end
    valid_nxt   = go ? 1'b1 : (out_ready ? 1'b0 : valid_r);
    scanned_nxt = go ? step : scanned_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= ssd_pkg::PERIOD_W'(ssd_pkg::PERIOD_RESET);
      shown_r   <= {ssd_pkg::DIGIT_COUNT{ssd_pkg::SEG_ZERO}};
      pend_r    <= 1'b0;
      idx_r     <= '0;
      tick_r    <= '0;
      seg_r     <= '0;
      en_r      <= '0;
      valid_r   <= 1'b0;
      scanned_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        period_r <= cfg_data;
      end
      shown_r   <= shown_nxt;
      pend_r    <= pend_nxt;
      idx_r     <= idx_nxt;
      tick_r    <= tick_nxt;
      seg_r     <= seg_nxt;
      en_r      <= en_nxt;
      valid_r   <= valid_nxt;
      scanned_r <= scanned_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (rd_item.op == ssd_pkg::OP_LOAD)) begin
      pending_r <= rd_item.pat;
    end
  end

endmodule

@@ sv/seven_segment_scan_driver.sv @@
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Three-digit multiplexed seven-segment driver: loads numbers, counts
// millisecond ticks and steps the digit scan every scan_period ticks.
// ----------------------------------------------------------------------------
// an accepted item is written into the queue, then its result is registered in the back stage
// throughput: one item per cycle while out_ready is high; a held result stalls the back step
// a two-word queue decouples decode from execution
// reset (rst_n low, synchronous): queue empty, no result held, period 4,
// digits show 000 once scanned, drive and enables off
module seven_segment_scan_driver (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssd_pkg::PERIOD_W-1:0]       cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic [ssd_pkg::NUMBER_W-1:0]       in_number,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ssd_pkg::SEG_W-1:0]          out_segments,
  output logic [ssd_pkg::DIGIT_COUNT-1:0]    out_digit_enable,
  output logic                               out_scanned
);

  logic           wr_valid;
  logic           wr_ready;
  ssd_pkg::item_t wr_item;
  logic           rd_valid;
  logic           rd_ready;
  ssd_pkg::item_t rd_item;

  assign cfg_ready = 1'b1;

  ssd_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_number (in_number),
    .wr_valid  (wr_valid),
    .wr_ready  (wr_ready),
    .wr_item   (wr_item)
  );

  ssd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_item  (wr_item),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_item  (rd_item)
  );

  ssd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .rd_valid         (rd_valid),
    .rd_ready         (rd_ready),
    .rd_item          (rd_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments     (out_segments),
    .out_digit_enable (out_digit_enable),
    .out_scanned      (out_scanned)
  );

endmodule

@@ sv/ssd_checker.sv @@
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks on the scan driver's result channel.
// ----------------------------------------------------------------------------
module ssd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [ssd_pkg::SEG_W-1:0]          out_segments,
  input logic [ssd_pkg::DIGIT_COUNT-1:0]    out_digit_enable,
  input logic                               out_scanned
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_segments) &&
      $stable(out_digit_enable) && $stable(out_scanned))
    else $error("stalled word changed");

  a_enable_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_digit_enable))
    else $error("more than one digit enabled");

  a_scan_enables: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scanned |-> $onehot(out_digit_enable))
    else $error("scan step without a digit enable");

  a_dark_before_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_digit_enable == '0) |-> (out_segments == '0))
    else $error("segments driven with all digits off");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("word held after reset");

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_segments     (out_segments),
  .out_digit_enable (out_digit_enable),
  .out_scanned      (out_scanned)
);

@@ tb/sv/ssd_scan_check.sv @@
// ----------------------------------------------------------------------------
// ssd_scan_check
// Watches the load/tick, result and period write channels of the seven
// segment scan driver. It keeps its own copy of the display state, works
// out the drive word that each accepted input word should produce and
// compares every result word, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module ssd_scan_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ssd_pkg::PERIOD_W-1:0]    cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_op,
  input  logic [ssd_pkg::NUMBER_W-1:0]    in_number,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [ssd_pkg::SEG_W-1:0]       out_segments,
  input  logic [ssd_pkg::DIGIT_COUNT-1:0] out_digit_enable,
  input  logic                            out_scanned,
  output int                              fail_count,
  output int                              outstanding,
  output int                              steps_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ssd_pkg::seg_t                   segs;
    logic [ssd_pkg::DIGIT_COUNT-1:0] enables;
    logic                            stepped;
  } drive_t;

  logic [ssd_pkg::PERIOD_W-1:0]    period;
  ssd_pkg::seg_t                   shown [ssd_pkg::DIGIT_COUNT];
  ssd_pkg::seg_t                   staged [ssd_pkg::DIGIT_COUNT];
  logic                            staged_live;
  logic [ssd_pkg::INDEX_W-1:0]     scan_pos;
  logic [ssd_pkg::PERIOD_W-1:0]    ms_count;
  ssd_pkg::seg_t                   seg_hold;
  logic [ssd_pkg::DIGIT_COUNT-1:0] enable_hold;
  drive_t                          expected_drive [$];
  drive_t                          fresh;
  drive_t                          want;
  int                              mismatches = 0;
  int                              steps = 0;

  assign fail_count = mismatches;
  assign steps_seen = steps;

  function automatic ssd_pkg::seg_t glyph(input int d);
    ssd_pkg::seg_t s;
    case (d)
      0:       s = 7'h3F;
      1:       s = 7'h06;
      2:       s = 7'h5B;
      3:       s = 7'h4F;
      4:       s = 7'h66;
      5:       s = 7'h6D;
      6:       s = 7'h7D;
      7:       s = 7'h07;
      8:       s = 7'h7F;
      default: s = 7'h6F;
    endcase
    return s;
  endfunction

  task automatic predict_drive(input ssd_pkg::op_t op,
                               input logic [ssd_pkg::NUMBER_W-1:0] raw,
                               output drive_t r);
    int n;
    r.stepped = 1'b0;
    if (op == ssd_pkg::OP_LOAD) begin
      n = (int'(raw) > ssd_pkg::NUMBER_MAX) ? ssd_pkg::NUMBER_MAX : int'(raw);
      staged[0] = glyph(n % 10);
      staged[1] = (n >= 10) ? glyph((n / 10) % 10) : ssd_pkg::SEG_BLANK;
      staged[2] = (n >= 100) ? glyph(n / 100) : ssd_pkg::SEG_BLANK;
      staged_live = 1'b1;
    end else begin
      ms_count = ms_count + 1'b1;
      if (ms_count >= period) begin
        ms_count = '0;
        if (staged_live) begin
          shown = staged;
          staged_live = 1'b0;
        end
        seg_hold = shown[scan_pos];
        enable_hold = '0;
        enable_hold[scan_pos] = 1'b1;
        scan_pos = (scan_pos == ssd_pkg::INDEX_W'(ssd_pkg::DIGIT_COUNT - 1)) ?
                   '0 : scan_pos + 1'b1;
        r.stepped = 1'b1;
      end
    end
    r.segs = seg_hold;
    r.enables = enable_hold;
  endtask

  function automatic void note_field(input string field, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, field, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      period = ssd_pkg::PERIOD_W'(ssd_pkg::PERIOD_RESET);
      shown = '{default: ssd_pkg::SEG_ZERO};
      staged = '{default: ssd_pkg::SEG_BLANK};
      staged_live = 1'b0;
      scan_pos = '0;
      ms_count = '0;
      seg_hold = ssd_pkg::SEG_BLANK;
      enable_hold = '0;
      expected_drive.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        period = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          mismatches++;
          $display("%0t: result word expected none, got segments %0h enable %0h scanned %0b",
                   $time, out_segments, out_digit_enable, out_scanned);
        end else begin
          want = expected_drive.pop_front();
          note_field("segments", int'(want.segs), int'(out_segments));
          note_field("digit_enable", int'(want.enables), int'(out_digit_enable));
          note_field("scanned", int'(want.stepped), int'(out_scanned));
          if (want.stepped)
            steps++;
        end
      end
      if (in_valid && in_ready) begin
        predict_drive(ssd_pkg::op_t'(in_op), in_number, fresh);
        expected_drive.push_back(fresh);
      end
      outstanding <= expected_drive.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the seven segment scan driver with directed and random load and
// tick words under several scan periods, with random idling on both
// channels and one long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TICK_MARK   = -1;
  localparam int LONG_HOLD   = 60;
  localparam int HOLD_AFTER  = 200;
  localparam int TIME_LIMIT  = 5_000_000;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [ssd_pkg::PERIOD_W-1:0]    cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_op;
  logic [ssd_pkg::NUMBER_W-1:0]    in_number;
  logic                            out_valid;
  logic                            out_ready;
  logic [ssd_pkg::SEG_W-1:0]       out_segments;
  logic [ssd_pkg::DIGIT_COUNT-1:0] out_digit_enable;
  logic                            out_scanned;

  int fail_count;
  int outstanding;
  int steps_seen;
  int sent_words = 0;
  int loads = 0;
  int ticks = 0;
  int settings = 0;
  bit calm = 1'b0;

  int plan [21] = '{1000, TICK_MARK, TICK_MARK, TICK_MARK,
                    0, TICK_MARK, TICK_MARK, TICK_MARK,
                    7, TICK_MARK, 42, TICK_MARK, TICK_MARK,
                    100, TICK_MARK, 341, 682, TICK_MARK, TICK_MARK,
                    1023, TICK_MARK};

  always #5 clk = ~clk;

  seven_segment_scan_driver dut (.*);

  ssd_scan_check scan_check (.*);

  function automatic logic [ssd_pkg::NUMBER_W-1:0] pick_number();
    case ($urandom_range(0, 5))
      0:       return ssd_pkg::NUMBER_W'($urandom_range(0, 9));
      1:       return ssd_pkg::NUMBER_W'($urandom_range(10, 99));
      2:       return ssd_pkg::NUMBER_W'($urandom_range(100, 999));
      3:       return ssd_pkg::NUMBER_W'($urandom_range(1000, 1023));
      default: return ssd_pkg::NUMBER_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic push_word(input ssd_pkg::op_t op,
                           input logic [ssd_pkg::NUMBER_W-1:0] num);
    in_valid  <= 1'b1;
    in_op     <= op;
    in_number <= num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_words++;
    if (op == ssd_pkg::OP_TICK) ticks++;
    else loads++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_period(input logic [ssd_pkg::PERIOD_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic random_words(input int count, input int tick_pct);
    for (int i = 0; i < count; i++)
      push_word(($urandom_range(0, 99) < tick_pct) ? ssd_pkg::OP_TICK : ssd_pkg::OP_LOAD,
                pick_number());
  endtask

  // result side: random stalls plus one long hold-off to fill the block
  initial begin
    bit long_done;
    long_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      if (!long_done && sent_words >= HOLD_AFTER) begin
        long_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_op     = ssd_pkg::OP_LOAD;
    in_number = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset period, blank drive until the first step shows 000
    repeat (4) push_word(ssd_pkg::OP_TICK, ssd_pkg::NUMBER_W'($urandom_range(0, 1023)));
    set_period(ssd_pkg::PERIOD_W'(1));
    foreach (plan[i])
      push_word(plan[i] == TICK_MARK ? ssd_pkg::OP_TICK : ssd_pkg::OP_LOAD,
                plan[i] == TICK_MARK ? pick_number() : ssd_pkg::NUMBER_W'(plan[i]));

    random_words(300, 50);
    set_period(ssd_pkg::PERIOD_W'(255));
    random_words(650, 92);
    set_period(ssd_pkg::PERIOD_W'(0));
    random_words(200, 50);
    set_period(ssd_pkg::PERIOD_W'($urandom_range(5, 40)));
    random_words(300, 75);
    set_period(ssd_pkg::PERIOD_W'(3));
    random_words(300, 70);
    calm = 1'b1;
    set_period(ssd_pkg::PERIOD_W'(2));
    random_words(150, 70);

    wait_drained();
    repeat (4) @(posedge clk);
    $display("covered %0d words (%0d loads, %0d ticks) over %0d period settings",
             sent_words, loads, ticks, settings);
    $display("%0d multiplex steps checked, %0d mismatches", steps_seen, fail_count);
    if (fail_count == 0)
      $display("** seven_segment_scan_driver: PASSED **");
    else
      $display("** seven_segment_scan_driver: FAILED **");
    $finish;
  end

  initial begin
    #(TIME_LIMIT);
    $display("timeout with %0d result words outstanding", outstanding);
    $display("** seven_segment_scan_driver: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
sv/ssd_pkg.sv
sv/ssd_front.sv
sv/ssd_queue.sv
sv/ssd_back.sv
sv/seven_segment_scan_driver.sv
sv/ssd_checker.sv
tb/sv/ssd_scan_check.sv
tb/sv/tb_top.sv
